// ===== rtl/i2cee_pkg.sv =====
package i2cee_pkg;

    // Register reset value
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;

    // Transaction phases
    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_START  = 5'd1;
    localparam logic [4:0] PH_RSTART = 5'd2;
    localparam logic [4:0] PH_ADDRW  = 5'd3;
    localparam logic [4:0] PH_ACK1   = 5'd4;
    localparam logic [4:0] PH_WORD   = 5'd5;
    localparam logic [4:0] PH_ACK2   = 5'd6;
    localparam logic [4:0] PH_DATA   = 5'd7;
    localparam logic [4:0] PH_ACK3   = 5'd8;
    localparam logic [4:0] PH_ADDRR  = 5'd9;
    localparam logic [4:0] PH_ACK4   = 5'd10;
    localparam logic [4:0] PH_READ   = 5'd11;
    localparam logic [4:0] PH_NACK   = 5'd12;
    localparam logic [4:0] PH_STOP   = 5'd13;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // One tick of input
    typedef struct packed {
        logic       sda_in;
        logic [7:0] write_data;
        logic [7:0] word_address;
        logic [6:0] device_address;
        logic       operation;
        logic       start_request;
    } i2cee_req_t;

    // One tick of result
    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
        logic       waiting_ack;
        logic       busy_res;
        logic       sda_release;
        logic       scl_level;
    } i2cee_res_t;

endpackage

// ===== rtl/i2cee_fsm.sv =====
module i2cee_fsm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  i2cee_pkg::i2cee_req_t  req,
    input  logic [7:0]             half_period,
    output i2cee_pkg::i2cee_res_t  res
);

    logic [4:0] phase_reg, phase_next;
    logic [1:0] seg_reg, seg_next;
    logic [7:0] tick_reg, tick_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic       lat_op_reg, lat_op_next;
    logic [6:0] lat_dev_reg, lat_dev_next;
    logic [7:0] lat_word_reg, lat_word_next;
    logic [7:0] lat_data_reg, lat_data_next;
    logic [7:0] rx_reg, rx_next;

    logic [7:0] h;
    logic       seg_end;
    logic [4:0] ph;
    logic       scl, sda, busy, wt, done;
    logic [7:0] rx_shift;

    // Bus levels from the current state, then the next state for this tick
    always_comb
    begin
        h        = (half_period == 8'd0) ? 8'd1 : half_period;
        seg_end  = ({1'b0, tick_reg} + 9'd1) >= {1'b0, h};
        ph       = (phase_reg > i2cee_pkg::PH_STOP) ? i2cee_pkg::PH_IDLE : phase_reg;
        rx_shift = {shift_reg[6:0], req.sda_in};

        scl  = 1'b1;
        sda  = 1'b1;
        busy = 1'b1;
        wt   = 1'b0;
        done = 1'b0;

        case (ph)
            i2cee_pkg::PH_IDLE:
            begin
                busy = 1'b0;
            end
            i2cee_pkg::PH_START, i2cee_pkg::PH_RSTART:
            begin
                scl = (seg_reg == 2'd1) || (seg_reg == 2'd2);
                sda = (seg_reg <= 2'd1);
            end
            i2cee_pkg::PH_ADDRW, i2cee_pkg::PH_WORD,
            i2cee_pkg::PH_DATA, i2cee_pkg::PH_ADDRR:
            begin
                scl = seg_reg[0];
                sda = shift_reg[7];
            end
            i2cee_pkg::PH_ACK1, i2cee_pkg::PH_ACK2,
            i2cee_pkg::PH_ACK3, i2cee_pkg::PH_ACK4:
            begin
                scl = seg_reg[0];
                wt  = seg_reg[0];
            end
            i2cee_pkg::PH_READ, i2cee_pkg::PH_NACK:
            begin
                scl = seg_reg[0];
            end
            default:
            begin
                // STOP
                scl = (seg_reg >= 2'd1);
                sda = (seg_reg == 2'd2);
            end
        endcase

        phase_next    = ph;
        seg_next      = seg_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        lat_op_next   = lat_op_reg;
        lat_dev_next  = lat_dev_reg;
        lat_word_next = lat_word_reg;
        lat_data_next = lat_data_reg;
        rx_next       = rx_reg;

        if (ph == i2cee_pkg::PH_IDLE)
        begin
            if (req.start_request)
            begin
                lat_op_next   = req.operation;
                lat_dev_next  = req.device_address;
                lat_word_next = req.word_address;
                lat_data_next = req.write_data;
                phase_next    = i2cee_pkg::PH_START;
                seg_next      = 2'd1;
                tick_next     = 8'd0;
            end
        end
        else if (!seg_end)
        begin
            tick_next = tick_reg + 8'd1;
        end
        else if (wt && req.sda_in)
        begin
            // no ACK yet: SCL stays high
        end
        else
        begin
            tick_next = 8'd0;
            case (ph)
                i2cee_pkg::PH_START, i2cee_pkg::PH_RSTART:
                begin
                    if (seg_reg < 2'd3)
                        seg_next = seg_reg + 2'd1;
                    else
                    begin
                        seg_next   = 2'd0;
                        bit_next   = 3'd0;
                        phase_next = (ph == i2cee_pkg::PH_START) ?
                                     i2cee_pkg::PH_ADDRW : i2cee_pkg::PH_ADDRR;
                        shift_next = {lat_dev_reg, ph == i2cee_pkg::PH_RSTART};
                    end
                end
                i2cee_pkg::PH_ADDRW, i2cee_pkg::PH_WORD,
                i2cee_pkg::PH_DATA, i2cee_pkg::PH_ADDRR:
                begin
                    if (seg_reg == 2'd0)
                        seg_next = 2'd1;
                    else
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        seg_next   = 2'd0;
                        bit_next   = bit_reg + 3'd1;
                        if (bit_reg == 3'd7)
                            phase_next = ph + 5'd1;
                    end
                end
                i2cee_pkg::PH_ACK1, i2cee_pkg::PH_ACK2,
                i2cee_pkg::PH_ACK3, i2cee_pkg::PH_ACK4:
                begin
                    if (seg_reg == 2'd0)
                        seg_next = 2'd1;
                    else
                    begin
                        seg_next = 2'd0;
                        bit_next = 3'd0;
                        case (ph)
                            i2cee_pkg::PH_ACK1:
                            begin
                                phase_next = i2cee_pkg::PH_WORD;
                                shift_next = lat_word_reg;
                            end
                            i2cee_pkg::PH_ACK2:
                            begin
                                if (lat_op_reg == i2cee_pkg::OP_READ)
                                begin
                                    phase_next = i2cee_pkg::PH_RSTART;
                                    shift_next = 8'd0;
                                end
                                else
                                begin
                                    phase_next = i2cee_pkg::PH_DATA;
                                    shift_next = lat_data_reg;
                                end
                            end
                            i2cee_pkg::PH_ACK3:
                            begin
                                phase_next = i2cee_pkg::PH_STOP;
                                shift_next = 8'd0;
                            end
                            default:
                            begin
                                phase_next = i2cee_pkg::PH_READ;
                                shift_next = 8'd0;
                            end
                        endcase
                    end
                end
                i2cee_pkg::PH_READ:
                begin
                    if (seg_reg == 2'd0)
                        seg_next = 2'd1;
                    else
                    begin
                        seg_next = 2'd0;
                        if (bit_reg == 3'd7)
                        begin
                            rx_next    = rx_shift;
                            phase_next = i2cee_pkg::PH_NACK;
                            shift_next = 8'd0;
                            bit_next   = 3'd0;
                        end
                        else
                        begin
                            shift_next = rx_shift;
                            bit_next   = bit_reg + 3'd1;
                        end
                    end
                end
                i2cee_pkg::PH_NACK:
                begin
                    if (seg_reg == 2'd0)
                        seg_next = 2'd1;
                    else
                    begin
                        seg_next   = 2'd0;
                        bit_next   = 3'd0;
                        shift_next = 8'd0;
                        phase_next = i2cee_pkg::PH_STOP;
                    end
                end
                default:
                begin
                    // STOP
                    if (seg_reg < 2'd2)
                        seg_next = seg_reg + 2'd1;
                    else
                    begin
                        done       = 1'b1;
                        seg_next   = 2'd0;
                        bit_next   = 3'd0;
                        shift_next = 8'd0;
                        phase_next = i2cee_pkg::PH_IDLE;
                    end
                end
            endcase
        end

        res.scl_level   = scl;
        res.sda_release = sda;
        res.busy_res    = busy;
        res.waiting_ack = wt;
        res.done_res    = done;
        res.read_data   = rx_next;
    end

    // State registers, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= i2cee_pkg::PH_IDLE;
            seg_reg      <= 2'd0;
            tick_reg     <= 8'd0;
            bit_reg      <= 3'd0;
            shift_reg    <= 8'd0;
            lat_op_reg   <= 1'b0;
            lat_dev_reg  <= 7'd0;
            lat_word_reg <= 8'd0;
            lat_data_reg <= 8'd0;
            rx_reg       <= 8'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            seg_reg      <= seg_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            lat_op_reg   <= lat_op_next;
            lat_dev_reg  <= lat_dev_next;
            lat_word_reg <= lat_word_next;
            lat_data_reg <= lat_data_next;
            rx_reg       <= rx_next;
        end
    end

    // Checks
    a_phase_known: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= i2cee_pkg::PH_STOP)
        else $error("phase left the known range");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.done_res) |=> (phase_reg == i2cee_pkg::PH_IDLE))
        else $error("STOP finished but not idle");

    a_ack_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.waiting_ack && req.sda_in) |=> (phase_reg == $past(phase_reg)))
        else $error("ACK clock ended without ACK");

    a_idle_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cee_pkg::PH_IDLE) |-> (bit_reg == 3'd0))
        else $error("bit index not cleared in idle");

endmodule

// ===== rtl/i2c_eeprom_byte_access_master_top.sv =====
// A result item is registered and appears on the master side in the cycle after its input item is taken.
// Throughput: one item per cycle while the master side is ready; the output register decouples the two sides.
// Each input item is one bus timing tick of the transaction state machine.
// Reset (rst_n, async, active low): idle bus, half period 5, read_data zero, no result pending.
module i2c_eeprom_byte_access_master_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // tdata: start_request[0], operation[1], device_address[8:2], word_address[16:9],
    //        write_data[24:17], sda_in[25], zero[31:26]
    input  logic [i2cee_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: scl_level[0], sda_release[1], busy_res[2], waiting_ack[3], done_res[4],
    //        read_data[12:5], zero[15:13]
    output logic [i2cee_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // half_period_ticks write
    input  logic [7:0]                         cfg_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready
);

    i2cee_pkg::i2cee_req_t req;
    i2cee_pkg::i2cee_res_t res;
    i2cee_pkg::i2cee_res_t out_reg;
    logic                  m_tvalid_reg;
    logic [7:0]            half_period_reg;
    logic                  step;

    // Input unpack and handshake
    assign req      = s_tdata[$bits(i2cee_pkg::i2cee_req_t)-1:0];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_period_reg <= i2cee_pkg::HALF_PERIOD_RESET;
        else if (cfg_valid && cfg_ready)
            half_period_reg <= cfg_data;
    end

    i2cee_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .req         (req),
        .half_period (half_period_reg),
        .res         (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (step)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(i2cee_pkg::OUT_TDATA_W - $bits(i2cee_pkg::i2cee_res_t)){1'b0}},
                       out_reg};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_OFF_CYCLES = 150;
    localparam int MAX_PRINTED     = 40;

    // Idle profiles: sender 36 / receiver 70, the reverse, then no idling
    localparam int MODE_SLOW_SINK   = 0;
    localparam int MODE_SLOW_SOURCE = 1;
    localparam int MODE_NO_IDLE     = 2;

    // Mirrors the bus sequencer tick by tick and holds the bus levels it should produce
    class bus_level_scoreboard;
        logic [7:0] half_period = i2cee_pkg::HALF_PERIOD_RESET;
        logic [4:0] phase       = i2cee_pkg::PH_IDLE;
        logic [7:0] tick_count  = '0;
        logic [2:0] bit_index   = '0;
        logic [7:0] shift_reg   = '0;
        logic [1:0] seg         = '0;
        logic       op_q        = 1'b0;
        logic [6:0] dev_q       = '0;
        logic [7:0] word_q      = '0;
        logic [7:0] data_q      = '0;
        logic [7:0] rx_byte     = '0;
        i2cee_pkg::i2cee_res_t expected_levels[$];
        int         errors      = 0;
        int         checked     = 0;

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] MISMATCH result %0d: %s", $realtime, checked, msg);
        endtask

        function void enter_phase(logic [4:0] p, logic [7:0] load);
            phase     = p;
            seg       = '0;
            bit_index = '0;
            shift_reg = load;
        endfunction

        // One bus tick: levels come from the state at the start of the tick
        function void note_tick(i2cee_pkg::i2cee_req_t req);
            i2cee_pkg::i2cee_res_t r;
            logic [8:0] hp;
            logic       seg_end;
            hp      = (half_period == 8'd0) ? 9'd1 : {1'b0, half_period};
            seg_end = ({1'b0, tick_count} + 9'd1) >= hp;
            r = '0;
            r.scl_level   = 1'b1;
            r.sda_release = 1'b1;
            r.busy_res    = 1'b1;
            if (phase > i2cee_pkg::PH_STOP)
                phase = i2cee_pkg::PH_IDLE;

            case (phase)
                i2cee_pkg::PH_IDLE:
                    r.busy_res = 1'b0;
                i2cee_pkg::PH_START, i2cee_pkg::PH_RSTART:
                begin
                    r.scl_level   = (seg == 2'd1) || (seg == 2'd2);
                    r.sda_release = (seg <= 2'd1);
                end
                i2cee_pkg::PH_ADDRW, i2cee_pkg::PH_WORD,
                i2cee_pkg::PH_DATA, i2cee_pkg::PH_ADDRR:
                begin
                    r.scl_level   = seg[0];
                    r.sda_release = shift_reg[7];
                end
                i2cee_pkg::PH_ACK1, i2cee_pkg::PH_ACK2,
                i2cee_pkg::PH_ACK3, i2cee_pkg::PH_ACK4:
                begin
                    r.scl_level   = seg[0];
                    r.waiting_ack = seg[0];
                end
                i2cee_pkg::PH_READ, i2cee_pkg::PH_NACK:
                    r.scl_level = seg[0];
                default:
                begin
                    r.scl_level   = (seg >= 2'd1);
                    r.sda_release = (seg == 2'd2);
                end
            endcase

            // next state
            if (phase == i2cee_pkg::PH_IDLE)
            begin
                if (req.start_request)
                begin
                    op_q       = req.operation;
                    dev_q      = req.device_address;
                    word_q     = req.word_address;
                    data_q     = req.write_data;
                    phase      = i2cee_pkg::PH_START;
                    seg        = 2'd1;
                    tick_count = '0;
                end
            end
            else if (!seg_end)
            begin
                tick_count++;
            end
            else if (r.waiting_ack && req.sda_in)
            begin
                // no ACK yet, SCL stays high
            end
            else
            begin
                tick_count = '0;
                case (phase)
                    i2cee_pkg::PH_START, i2cee_pkg::PH_RSTART:
                    begin
                        if (seg < 2'd3)
                            seg++;
                        else if (phase == i2cee_pkg::PH_START)
                            enter_phase(i2cee_pkg::PH_ADDRW, {dev_q, 1'b0});
                        else
                            enter_phase(i2cee_pkg::PH_ADDRR, {dev_q, 1'b1});
                    end
                    i2cee_pkg::PH_ADDRW, i2cee_pkg::PH_WORD,
                    i2cee_pkg::PH_DATA, i2cee_pkg::PH_ADDRR:
                    begin
                        if (seg == 2'd0)
                        begin
                            seg = 2'd1;
                        end
                        else
                        begin
                            shift_reg = shift_reg << 1;
                            seg       = 2'd0;
                            if (bit_index == 3'd7)
                            begin
                                phase     = phase + 5'd1;
                                bit_index = '0;
                            end
                            else
                            begin
                                bit_index++;
                            end
                        end
                    end
                    i2cee_pkg::PH_ACK1, i2cee_pkg::PH_ACK2,
                    i2cee_pkg::PH_ACK3, i2cee_pkg::PH_ACK4:
                    begin
                        if (seg == 2'd0)
                            seg = 2'd1;
                        else if (phase == i2cee_pkg::PH_ACK1)
                            enter_phase(i2cee_pkg::PH_WORD, word_q);
                        else if (phase == i2cee_pkg::PH_ACK2)
                        begin
                            if (op_q == i2cee_pkg::OP_READ)
                                enter_phase(i2cee_pkg::PH_RSTART, 8'd0);
                            else
                                enter_phase(i2cee_pkg::PH_DATA, data_q);
                        end
                        else if (phase == i2cee_pkg::PH_ACK3)
                            enter_phase(i2cee_pkg::PH_STOP, 8'd0);
                        else
                            enter_phase(i2cee_pkg::PH_READ, 8'd0);
                    end
                    i2cee_pkg::PH_READ:
                    begin
                        if (seg == 2'd0)
                        begin
                            seg = 2'd1;
                        end
                        else
                        begin
                            shift_reg = {shift_reg[6:0], req.sda_in};
                            seg       = 2'd0;
                            if (bit_index == 3'd7)
                            begin
                                rx_byte = shift_reg;
                                enter_phase(i2cee_pkg::PH_NACK, 8'd0);
                            end
                            else
                            begin
                                bit_index++;
                            end
                        end
                    end
                    i2cee_pkg::PH_NACK:
                    begin
                        if (seg == 2'd0)
                            seg = 2'd1;
                        else
                            enter_phase(i2cee_pkg::PH_STOP, 8'd0);
                    end
                    default:
                    begin
                        if (seg < 2'd2)
                        begin
                            seg++;
                        end
                        else
                        begin
                            r.done_res = 1'b1;
                            enter_phase(i2cee_pkg::PH_IDLE, 8'd0);
                        end
                    end
                endcase
            end

            r.read_data = rx_byte;
            expected_levels.push_back(r);
        endfunction

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_levels(logic [i2cee_pkg::OUT_TDATA_W-1:0] data);
            i2cee_pkg::i2cee_res_t got;
            i2cee_pkg::i2cee_res_t want;
            got = data[$bits(i2cee_pkg::i2cee_res_t)-1:0];
            if (expected_levels.size() == 0)
            begin
                report("result item with no tick pending");
                return;
            end
            want = expected_levels.pop_front();
            compare_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
            compare_field("sda_release", 8'(got.sda_release), 8'(want.sda_release));
            compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            compare_field("waiting_ack", 8'(got.waiting_ack), 8'(want.waiting_ack));
            compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
            compare_field("read_data", got.read_data, want.read_data);
            checked++;
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic [i2cee_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [i2cee_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [7:0]                        cfg_data;
    logic                              cfg_valid;
    logic                              cfg_ready;

    bus_level_scoreboard sb;
    int idle_mode        = MODE_NO_IDLE;
    bit hold_off_request = 1'b0;

    i2c_eeprom_byte_access_master_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the bus or the handshake hangs
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic i2cee_pkg::i2cee_req_t make_tick(logic start, logic op,
                                                        logic [6:0] dev,
                                                        logic [7:0] word,
                                                        logic [7:0] data,
                                                        logic sda);
        i2cee_pkg::i2cee_req_t t;
        t.start_request  = start;
        t.operation      = op;
        t.device_address = dev;
        t.word_address   = word;
        t.write_data     = data;
        t.sda_in         = sda;
        return t;
    endfunction

    // Random tick: SDA low two times in three so ACK waits end and the bus moves on
    function automatic i2cee_pkg::i2cee_req_t random_tick();
        i2cee_pkg::i2cee_req_t t;
        logic [31:0]           raw;
        raw      = $urandom;
        t        = raw[$bits(i2cee_pkg::i2cee_req_t)-1:0];
        t.sda_in = ($urandom_range(2) == 0);
        return t;
    endfunction

    // Offer one tick item, with random idle cycles ahead of it per the current profile
    task automatic send_tick(input i2cee_pkg::i2cee_req_t t);
        int gap_pct;
        gap_pct = (idle_mode == MODE_SLOW_SINK) ? 36 :
                  (idle_mode == MODE_SLOW_SOURCE) ? 70 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {{(i2cee_pkg::IN_TDATA_W - $bits(i2cee_pkg::i2cee_req_t)){1'b0}}, t};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_tick(t);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.expected_levels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_half_period(input logic [7:0] value);
        drain_results();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.half_period = value;
    endtask

    // Result side: check accepted items, randomize ready, honor long hold-offs
    initial
    begin
        int hold_left;
        int stall_pct;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_levels(m_tdata);
            if (hold_off_request)
            begin
                hold_left        = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            stall_pct = (idle_mode == MODE_SLOW_SINK) ? 70 :
                        (idle_mode == MODE_SLOW_SOURCE) ? 36 : 0;
            if (!rst_n)
                m_tready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        int i;
        sb = new;
        rst_n     <= 1'b0;
        s_tdata   <= '0;
        s_tvalid  <= 1'b0;
        cfg_data  <= '0;
        cfg_valid <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle bus with field extremes, then a read with all-ones fields
        send_tick(make_tick(1'b0, i2cee_pkg::OP_WRITE, 7'd0, 8'd0, 8'd0, 1'b0));
        send_tick(make_tick(1'b0, i2cee_pkg::OP_READ, 7'h7f, 8'hff, 8'hff, 1'b1));
        send_tick(make_tick(1'b1, i2cee_pkg::OP_READ, 7'h7f, 8'hff, 8'hff, 1'b1));
        // requests while busy must be ignored
        send_tick(make_tick(1'b1, i2cee_pkg::OP_WRITE, 7'd0, 8'd0, 8'd0, 1'b0));
        send_tick(make_tick(1'b1, i2cee_pkg::OP_WRITE, 7'h55, 8'haa, 8'h55, 1'b1));
        for (i = 0; i < 7; i++)
            send_tick(make_tick(1'b1, i[0], 7'h2a ^ 7'(i), 8'h0f << i, 8'hf0 >> i, i[1]));

        // zero half period acts as one
        write_half_period(8'd0);
        for (i = 0; i < 12; i++)
            send_tick(make_tick(1'b1, ~i[0], 7'(i * 9), 8'(i * 21), 8'(255 - i), i[0]));

        // fastest bus, slow receiver
        write_half_period(8'd1);
        idle_mode = MODE_SLOW_SINK;
        for (i = 0; i < 350; i++)
            send_tick(random_tick());

        // slow sender, plus one long receiver hold-off that backs up the input
        write_half_period(8'd2);
        idle_mode = MODE_SLOW_SOURCE;
        for (i = 0; i < 300; i++)
        begin
            if (i == 120)
                hold_off_request = 1'b1;
            send_tick(random_tick());
        end

        // slowest bus, partial transaction only
        write_half_period(8'hff);
        idle_mode = MODE_NO_IDLE;
        for (i = 0; i < 150; i++)
            send_tick(random_tick());

        // fastest bus again, with a full drain in the middle
        write_half_period(8'd1);
        for (i = 0; i < 300; i++)
        begin
            if (i == 150)
                drain_results();
            send_tick(random_tick());
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
